[hw/rtl/srpg_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// srpg_pkg
// Shared widths, constants, controller states and the command and status
// structs of the stepper ramp pulse generator.
// ----------------------------------------------------------------------------
package srpg_pkg;

  localparam int STEP_COUNT_BITS_DEF = 20;
  localparam int ANGLE_W             = 16;
  localparam int SPEED_W             = 16;
  localparam int MUL5_W              = 19;
  localparam int HALF_W              = 19;
  localparam int MS_W                = 2;
  localparam int MS_SHIFT_W          = 3;
  localparam int COUNT_DIVISOR       = 9;
  localparam int CNT_NUM_W           = MUL5_W + 4;
  localparam int CNT_RECIP_W         = 24;
  localparam int CNT_RECIP_SHIFT     = 27;

  // The rounded-up reciprocal is exact for every count numerator below 2^23.
  localparam logic [CNT_RECIP_W-1:0] CNT_RECIP =
    CNT_RECIP_W'(((64'd1 << CNT_RECIP_SHIFT) + COUNT_DIVISOR - 1) / COUNT_DIVISOR);

  localparam logic [HALF_W-1:0] HALF_MAX = {HALF_W{1'b1}};

  localparam logic REQ_START = 1'b0;
  localparam logic REQ_TICK  = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DISPATCH,
    ST_CNT_SETUP,
    ST_CNT_END,
    ST_TICK,
    ST_HALF_SETUP,
    ST_HALF_MUL,
    ST_HALF_DIV,
    ST_HALF_END,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic load;
    logic ignore;
    logic cnt_setup;
    logic div_step;
    logic cnt_end;
    logic tick;
    logic half_setup;
    logic half_mul;
    logic half_end;
    logic out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic is_tick;
    logic active;
    logic step_pin;
    logic boundary;
    logic last_step;
    logic div_last;
    logic cnt_zero;
    logic out_free;
  } dp_sts_t;

  // Log2 of the microstep count selected by the ms1/ms2 pins.
  function automatic logic [MS_SHIFT_W-1:0] ms_shift(input logic [MS_W-1:0] pins);
    logic [MS_SHIFT_W-1:0] sh;
    unique case (pins)
      2'b11:   sh = 3'd4;
      2'b00:   sh = 3'd3;
      2'b01:   sh = 3'd2;
      2'b10:   sh = 3'd1;
      default: sh = 3'd3;
    endcase
    return sh;
  endfunction

endpackage
`default_nettype wire

[hw/rtl/srpg_cmd_if.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// srpg_cmd_if
// Valid/ready channel carrying move commands and microsecond ticks.
// ----------------------------------------------------------------------------
interface srpg_cmd_if;
  logic                          valid;
  logic                          ready;
  logic                          req_type;
  logic                          direction;
  logic [srpg_pkg::ANGLE_W-1:0]  angle;
  logic [srpg_pkg::SPEED_W-1:0]  speed;

  modport source (output valid, output req_type, output direction, output angle,
                  output speed, input ready);
  modport sink   (input valid, input req_type, input direction, input angle,
                  input speed, output ready);
endinterface
`default_nettype wire

[hw/rtl/srpg_res_if.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// srpg_res_if
// Valid/ready channel carrying the pin levels and status after each transaction.
// ----------------------------------------------------------------------------
interface srpg_res_if;
  logic valid;
  logic ready;
  logic step_level;
  logic dir_level;
  logic enable_level;
  logic busy_res;
  logic start_ignored;

  modport source (output valid, output step_level, output dir_level,
                  output enable_level, output busy_res, output start_ignored,
                  input ready);
  modport sink   (input valid, input step_level, input dir_level,
                  input enable_level, input busy_res, input start_ignored,
                  output ready);
endinterface
`default_nettype wire

[hw/rtl/stepper_ramp_pulse_generator_top.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// stepper_ramp_pulse_generator_top
// Trapezoidal ramp step pulse generator driven by move commands and ticks.
//
//   Channel   Direction  Handshake     Contents
//   in_cmd    sink       valid/ready   req_type, direction, angle, speed
//   out_res   source     valid/ready   step, dir, enable levels, busy, ignored
//   cfg_*     input      write enable  microstep pins
//
// An idle tick or an ignored start passes from dispatch straight to the result hand-off;
// any other tick passes through the tick state, and one that starts a step then runs the
// half period setup, the multiply and the bit-serial divider (STEP_COUNT_BITS + 18 steps).
// A start first scales the step count, and skips the half period when the move has no steps.
// Reset is synchronous; a stalled result holds while the next transaction enters,
// and the next result waits until the held one is taken.
// ----------------------------------------------------------------------------
module stepper_ramp_pulse_generator_top #(
  parameter int STEP_COUNT_BITS = srpg_pkg::STEP_COUNT_BITS_DEF
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  srpg_cmd_if.sink                        in_cmd,
  srpg_res_if.source                      out_res,
  input  wire logic                       cfg_we,
  input  wire logic [srpg_pkg::MS_W-1:0]  cfg_wdata
);

  srpg_pkg::dp_cmd_t cmd;
  srpg_pkg::dp_sts_t sts;

  srpg_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_cmd.valid),
    .in_ready (in_cmd.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  srpg_datapath #(
    .STEP_COUNT_BITS (STEP_COUNT_BITS)
  ) u_datapath (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .sts               (sts),
    .in_req_type       (in_cmd.req_type),
    .in_direction      (in_cmd.direction),
    .in_angle          (in_cmd.angle),
    .in_speed          (in_cmd.speed),
    .cfg_we            (cfg_we),
    .cfg_wdata         (cfg_wdata),
    .out_ready         (out_res.ready),
    .out_valid         (out_res.valid),
    .out_step_level    (out_res.step_level),
    .out_dir_level     (out_res.dir_level),
    .out_enable_level  (out_res.enable_level),
    .out_busy_res      (out_res.busy_res),
    .out_start_ignored (out_res.start_ignored)
  );

endmodule
`default_nettype wire

[hw/rtl/srpg_ctrl.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// srpg_ctrl
// Controller state machine: sequences command decode, step count scaling,
// tick handling, half period computation and result hand-off.
// ----------------------------------------------------------------------------
module srpg_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire srpg_pkg::dp_sts_t sts,
  output srpg_pkg::dp_cmd_t      cmd
);

  srpg_pkg::state_t state_r;
  srpg_pkg::state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= srpg_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      srpg_pkg::ST_IDLE: begin
        if (in_valid) state_nxt = srpg_pkg::ST_DISPATCH;
      end
      srpg_pkg::ST_DISPATCH: begin
        if (sts.is_tick) begin
          state_nxt = sts.active ? srpg_pkg::ST_TICK : srpg_pkg::ST_DONE;
        end else begin
          state_nxt = sts.active ? srpg_pkg::ST_DONE : srpg_pkg::ST_CNT_SETUP;
        end
      end
      srpg_pkg::ST_CNT_SETUP: state_nxt = srpg_pkg::ST_CNT_END;
      srpg_pkg::ST_CNT_END: begin
        state_nxt = sts.cnt_zero ? srpg_pkg::ST_DONE : srpg_pkg::ST_HALF_SETUP;
      end
      srpg_pkg::ST_TICK: begin
        if (sts.boundary && !sts.step_pin && !sts.last_step) begin
          state_nxt = srpg_pkg::ST_HALF_SETUP;
        end else begin
          state_nxt = srpg_pkg::ST_DONE;
        end
      end
      srpg_pkg::ST_HALF_SETUP: state_nxt = srpg_pkg::ST_HALF_MUL;
      srpg_pkg::ST_HALF_MUL:   state_nxt = srpg_pkg::ST_HALF_DIV;
      srpg_pkg::ST_HALF_DIV: begin
        if (sts.div_last) state_nxt = srpg_pkg::ST_HALF_END;
      end
      srpg_pkg::ST_HALF_END: state_nxt = srpg_pkg::ST_DONE;
      srpg_pkg::ST_DONE: begin
        if (sts.out_free) state_nxt = srpg_pkg::ST_IDLE;
      end
      default: state_nxt = srpg_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    unique case (state_r)
      srpg_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      srpg_pkg::ST_DISPATCH:   cmd.ignore     = !sts.is_tick && sts.active;
      srpg_pkg::ST_CNT_SETUP:  cmd.cnt_setup  = 1'b1;
      srpg_pkg::ST_CNT_END:    cmd.cnt_end    = 1'b1;
      srpg_pkg::ST_TICK:       cmd.tick       = 1'b1;
      srpg_pkg::ST_HALF_SETUP: cmd.half_setup = 1'b1;
      srpg_pkg::ST_HALF_MUL:   cmd.half_mul   = 1'b1;
      srpg_pkg::ST_HALF_DIV:   cmd.div_step   = 1'b1;
      srpg_pkg::ST_HALF_END:   cmd.half_end   = 1'b1;
      srpg_pkg::ST_DONE:       cmd.out_load   = sts.out_free;
      default: begin
        cmd      = '0;
        in_ready = 1'b0;
      end
    endcase
  end

endmodule
`default_nettype wire

[hw/rtl/srpg_datapath.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// srpg_datapath
// Motion state, ramp factor setup, one multiplier, a reciprocal multiplier for
// the step count, a restoring divider producing one quotient bit per cycle for
// the half period, and the result register.
// ----------------------------------------------------------------------------
module srpg_datapath #(
  parameter int STEP_COUNT_BITS = srpg_pkg::STEP_COUNT_BITS_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire srpg_pkg::dp_cmd_t              cmd,
  output srpg_pkg::dp_sts_t                   sts,
  input  wire logic                           in_req_type,
  input  wire logic                           in_direction,
  input  wire logic [srpg_pkg::ANGLE_W-1:0]   in_angle,
  input  wire logic [srpg_pkg::SPEED_W-1:0]   in_speed,
  input  wire logic                           cfg_we,
  input  wire logic [srpg_pkg::MS_W-1:0]      cfg_wdata,
  input  wire logic                           out_ready,
  output logic                                out_valid,
  output logic                                out_step_level,
  output logic                                out_dir_level,
  output logic                                out_enable_level,
  output logic                                out_busy_res,
  output logic                                out_start_ignored
);

  localparam int CNT_W   = STEP_COUNT_BITS;
  localparam int PART_W  = CNT_W - 2;
  localparam int FAC_W   = CNT_W - 1;
  localparam int NUM_W   = srpg_pkg::MUL5_W + FAC_W;
  localparam int DEN_W   = PART_W + 5;
  localparam int DCNT_W  = $clog2(NUM_W);
  localparam int HW      = srpg_pkg::HALF_W;
  localparam int CNUM_W  = srpg_pkg::CNT_NUM_W;
  localparam int CPROD_W = CNUM_W + srpg_pkg::CNT_RECIP_W;
  localparam int CQ_W    = CPROD_W - srpg_pkg::CNT_RECIP_SHIFT;
  localparam int CX_W    = (CQ_W > CNT_W) ? CQ_W : CNT_W;

  logic                           req_type_r;
  logic                           req_dir_r;
  logic [srpg_pkg::ANGLE_W-1:0]   req_angle_r;
  logic [srpg_pkg::SPEED_W-1:0]   req_speed_r;
  logic [srpg_pkg::MS_W-1:0]      ms_pins_r;

  logic                           active_r;
  logic                           dir_r;
  logic                           step_r;
  logic                           en_r;
  logic                           ign_r;
  logic [CNT_W-1:0]               total_r;
  logic [CNT_W-1:0]               idx_r;
  logic [HW-1:0]                  htl_r;
  logic [HW-1:0]                  hp_r;
  logic [srpg_pkg::SPEED_W-1:0]   speed_r;

  logic [FAC_W-1:0]               fac_r;
  logic [DEN_W-1:0]               den_r;
  logic [DEN_W-1:0]               rem_r;
  logic [NUM_W-1:0]               quo_r;
  logic [DCNT_W-1:0]              dcnt_r;
  logic [CPROD_W-1:0]             cprod_r;

  logic [srpg_pkg::MS_SHIFT_W-1:0] ms_sh;
  logic [srpg_pkg::MUL5_W-1:0]     speed5;
  logic [srpg_pkg::MUL5_W-1:0]     angle5;
  logic [CNUM_W-1:0]               cnt_num;
  logic [CQ_W-1:0]                 cnt_quo;
  logic [CX_W-1:0]                 cnt_wide;
  logic [NUM_W-1:0]                prod;
  logic [PART_W-1:0]               part;
  logic [FAC_W-1:0]                part2;
  logic                            first_q;
  logic                            last_q;
  logic [CNT_W-1:0]                tail_len;
  logic [FAC_W-1:0]                fac_nxt;
  logic [PART_W-1:0]               dpart;
  logic [DEN_W-1:0]                den_nxt;
  logic [DEN_W:0]                  trial;
  logic [DEN_W:0]                  diff;
  logic                            ge;
  logic [DEN_W-1:0]                rem_nxt;
  logic [NUM_W-1:0]                quo_nxt;
  logic [HW-1:0]                   half_q;
  logic [CNT_W-1:0]                count_q;
  logic [CNT_W-1:0]                idx_inc;
  logic [HW-1:0]                   htl_dec;

  assign ms_sh   = srpg_pkg::ms_shift(ms_pins_r);
  assign speed5  = ({3'b000, speed_r} << 2) + {3'b000, speed_r};
  assign angle5  = ({3'b000, req_angle_r} << 2) + {3'b000, req_angle_r};
  assign cnt_num = CNUM_W'(angle5) << ms_sh;
  assign prod    = speed5 * fac_r;

  assign part     = total_r[CNT_W-1:2];
  assign part2    = {part, 1'b0};
  assign first_q  = idx_r < {2'b00, part};
  assign last_q   = (part != '0) &&
                    (({1'b0, idx_r} + {3'b000, part}) > {1'b0, total_r});
  assign tail_len = total_r - idx_r;

  always_comb begin
    if (first_q) begin
      fac_nxt = part2 - FAC_W'(idx_r);
      dpart   = part;
    end else if (last_q) begin
      fac_nxt = part2 - FAC_W'(tail_len);
      dpart   = part;
    end else begin
      fac_nxt = FAC_W'(1);
      dpart   = PART_W'(1);
    end
  end

  assign den_nxt = {5'b00000, dpart} << (ms_sh + 3'd1);

  assign trial   = {rem_r, quo_r[NUM_W-1]};
  assign diff    = trial - {1'b0, den_r};
  assign ge      = trial >= {1'b0, den_r};
  assign rem_nxt = ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
  assign quo_nxt = {quo_r[NUM_W-2:0], ge};

  always_comb begin
    if (|quo_r[NUM_W-1:HW]) begin
      half_q = srpg_pkg::HALF_MAX;
    end else if (quo_r[HW-1:0] == '0) begin
      half_q = HW'(1);
    end else begin
      half_q = quo_r[HW-1:0];
    end
  end

  assign cnt_quo  = cprod_r[CPROD_W-1:srpg_pkg::CNT_RECIP_SHIFT];
  assign cnt_wide = CX_W'(cnt_quo);
  assign count_q  = (cnt_wide > CX_W'({CNT_W{1'b1}})) ? {CNT_W{1'b1}} :
                    cnt_wide[CNT_W-1:0];
  assign idx_inc  = idx_r + CNT_W'(1);
  assign htl_dec  = (htl_r != '0) ? (htl_r - HW'(1)) : '0;

  assign sts.is_tick   = (req_type_r == srpg_pkg::REQ_TICK);
  assign sts.active    = active_r;
  assign sts.step_pin  = step_r;
  assign sts.boundary  = (htl_r[HW-1:1] == '0);
  assign sts.last_step = idx_inc >= total_r;
  assign sts.div_last  = (dcnt_r == DCNT_W'(NUM_W - 1));
  assign sts.cnt_zero  = (cnt_quo == '0);
  assign sts.out_free  = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ms_pins_r <= '0;
      active_r  <= 1'b0;
      dir_r     <= 1'b0;
      step_r    <= 1'b0;
      en_r      <= 1'b1;
      ign_r     <= 1'b0;
      total_r   <= '0;
      idx_r     <= '0;
      htl_r     <= '0;
      hp_r      <= '0;
      speed_r   <= '0;
      dcnt_r    <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_we) ms_pins_r <= cfg_wdata;
      if (cmd.load) ign_r <= 1'b0;
      if (cmd.ignore) ign_r <= 1'b1;
      if (cmd.half_mul) dcnt_r <= '0;
      if (cmd.div_step) dcnt_r <= dcnt_r + DCNT_W'(1);
      if (cmd.cnt_end) begin
        total_r <= count_q;
        idx_r   <= '0;
        dir_r   <= req_dir_r;
        speed_r <= req_speed_r;
        if (sts.cnt_zero) begin
          en_r   <= 1'b1;
          step_r <= 1'b0;
        end
      end
      if (cmd.tick) begin
        if (htl_dec == '0) begin
          if (step_r) begin
            step_r <= 1'b0;
            htl_r  <= hp_r;
          end else begin
            idx_r <= idx_inc;
            htl_r <= '0;
            if (idx_inc >= total_r) begin
              active_r <= 1'b0;
              en_r     <= 1'b1;
            end
          end
        end else begin
          htl_r <= htl_dec;
        end
      end
      if (cmd.half_end) begin
        hp_r     <= half_q;
        htl_r    <= half_q;
        step_r   <= 1'b1;
        active_r <= 1'b1;
        en_r     <= 1'b0;
      end
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_type_r  <= in_req_type;
      req_dir_r   <= in_direction;
      req_angle_r <= in_angle;
      req_speed_r <= in_speed;
    end
    if (cmd.cnt_setup) begin
      cprod_r <= cnt_num * srpg_pkg::CNT_RECIP;
    end
    if (cmd.half_setup) begin
      fac_r <= fac_nxt;
      den_r <= den_nxt;
    end
    if (cmd.half_mul) begin
      quo_r <= prod;
      rem_r <= '0;
    end
    if (cmd.div_step) begin
      quo_r <= quo_nxt;
      rem_r <= rem_nxt;
    end
    if (cmd.out_load) begin
      out_step_level    <= step_r;
      out_dir_level     <= dir_r;
      out_enable_level  <= en_r;
      out_busy_res      <= active_r;
      out_start_ignored <= ign_r;
    end
  end

endmodule
`default_nettype wire

[tb/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the stepper ramp pulse generator. A driver and a
// monitor run as clocked processes on the command and result channels, with
// random idle gaps on both. Every accepted command is run through an
// independent model of the ramp generator, and each returned transaction is
// compared against the oldest predicted pin and status levels. Directed
// moves cover idle ticks, zero-step moves, zero speed and starts during a
// move; random phases then sweep every microstep setting.
// ----------------------------------------------------------------------------
module tb;

  localparam int STEP_BITS = srpg_pkg::STEP_COUNT_BITS_DEF;
  localparam longint unsigned COUNT_MAX = (64'd1 << STEP_BITS) - 1;
  localparam int SETTLE_CYCLES = 2 * (STEP_BITS + 18) + 30;
  localparam int RANDOM_ITEMS = 1350;
  localparam int PHASE_ITEMS = 150;

  localparam logic [srpg_pkg::MS_W-1:0] MS_PINS_16 = 2'b11;
  localparam logic [srpg_pkg::MS_W-1:0] MS_PINS_8  = 2'b00;
  localparam logic [srpg_pkg::MS_W-1:0] MS_PINS_4  = 2'b01;
  localparam logic [srpg_pkg::MS_W-1:0] MS_PINS_2  = 2'b10;

  typedef logic [srpg_pkg::ANGLE_W-1:0] angle_t;
  typedef logic [srpg_pkg::SPEED_W-1:0] speed_t;

  typedef struct packed {
    logic   req_type;
    logic   direction;
    angle_t angle;
    speed_t speed;
  } move_cmd_t;

  typedef struct packed {
    bit step;
    bit dir;
    bit enable;
    bit busy;
    bit ignored;
  } pin_levels_t;

  typedef struct packed {
    bit                          active;
    bit                          dir;
    bit                          step_pin;
    bit                          enable;
    bit [STEP_BITS-1:0]          total;
    bit [STEP_BITS-1:0]          idx;
    bit [srpg_pkg::HALF_W-1:0]   ticks_left;
    bit [srpg_pkg::HALF_W-1:0]   half;
    bit [srpg_pkg::SPEED_W-1:0]  speed;
    bit [srpg_pkg::MS_W-1:0]     ms_pins;
  } ramp_state_t;

  logic                      clk;
  logic                      rst_n;
  logic                      cfg_we;
  logic [srpg_pkg::MS_W-1:0] cfg_wdata;

  srpg_cmd_if cmd_bus ();
  srpg_res_if res_bus ();

  stepper_ramp_pulse_generator_top u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_cmd    (cmd_bus),
    .out_res   (res_bus),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  move_cmd_t   cmd_pending[$];
  pin_levels_t levels_expected[$];
  ramp_state_t plan_st;
  ramp_state_t live_st;
  move_cmd_t   sent_cmd;
  pin_levels_t got_want;
  int          useful_items;
  int          mismatches;
  int          send_wait;
  int          recv_wait;
  bit          send_calm;
  bit          recv_calm;
  logic [srpg_pkg::MS_W-1:0] ms_order [4];

  function automatic longint unsigned microsteps(input bit [srpg_pkg::MS_W-1:0] pins);
    case (pins)
      MS_PINS_16: return 16;
      MS_PINS_8:  return 8;
      MS_PINS_4:  return 4;
      default:    return 2;
    endcase
  endfunction

  function automatic bit [srpg_pkg::HALF_W-1:0] ramp_half(input ramp_state_t s,
                                                          input bit [STEP_BITS-1:0] i);
    longint unsigned m, total, part, idx, spd, num, den, q;
    m = microsteps(s.ms_pins);
    total = s.total;
    part = total / 4;
    idx = i;
    spd = s.speed;
    if (idx < part) begin
      num = spd * 5 * (2 * part - idx);
      den = 2 * m * part;
    end else if (part > 0 && idx + part > total) begin
      num = spd * 5 * (2 * part - (total - idx));
      den = 2 * m * part;
    end else begin
      num = spd * 5;
      den = 2 * m;
    end
    q = num / den;
    if (q < 1) q = 1;
    if (q > srpg_pkg::HALF_MAX) q = srpg_pkg::HALF_MAX;
    return q[srpg_pkg::HALF_W-1:0];
  endfunction

  function automatic pin_levels_t ramp_step(inout ramp_state_t s, input move_cmd_t c);
    pin_levels_t r;
    longint unsigned cnt;
    r.ignored = 1'b0;
    if (c.req_type == srpg_pkg::REQ_START) begin
      if (s.active) begin
        r.ignored = 1'b1;
      end else begin
        cnt = c.angle * microsteps(s.ms_pins) * 5 / 9;
        if (cnt > COUNT_MAX) cnt = COUNT_MAX;
        s.dir = c.direction;
        s.speed = c.speed;
        s.total = cnt[STEP_BITS-1:0];
        s.idx = '0;
        if (cnt == 0) begin
          s.enable = 1'b1;
          s.step_pin = 1'b0;
        end else begin
          s.enable = 1'b0;
          s.active = 1'b1;
          s.half = ramp_half(s, '0);
          s.ticks_left = s.half;
          s.step_pin = 1'b1;
        end
      end
    end else if (s.active) begin
      if (s.ticks_left > 0) s.ticks_left = s.ticks_left - 1'b1;
      if (s.ticks_left == 0) begin
        if (s.step_pin) begin
          s.step_pin = 1'b0;
          s.ticks_left = s.half;
        end else begin
          s.idx = s.idx + 1'b1;
          if (s.idx >= s.total) begin
            s.active = 1'b0;
            s.enable = 1'b1;
          end else begin
            s.half = ramp_half(s, s.idx);
            s.ticks_left = s.half;
            s.step_pin = 1'b1;
          end
        end
      end
    end
    r.step = s.step_pin;
    r.dir = s.dir;
    r.enable = s.enable;
    r.busy = s.active;
    return r;
  endfunction

  function automatic ramp_state_t ramp_reset_state();
    ramp_state_t s;
    s = '0;
    s.enable = 1'b1;
    s.ms_pins = MS_PINS_8;
    return s;
  endfunction

  function automatic move_cmd_t make_cmd(input logic kind, input logic dir,
                                         input angle_t angle, input speed_t speed);
    move_cmd_t c;
    c.req_type = kind;
    c.direction = dir;
    c.angle = angle;
    c.speed = speed;
    return c;
  endfunction

  function automatic move_cmd_t rand_cmd(input logic kind);
    return make_cmd(kind, 1'($urandom_range(0, 1)), angle_t'($urandom_range(0, 65535)),
                    speed_t'($urandom_range(0, 65535)));
  endfunction

  function automatic int idle_draw(inout bit calm);
    if ($urandom_range(0, 39) == 0) calm = !calm;
    return calm ? 0 : int'($urandom_range(0, 11));
  endfunction

  task automatic queue_cmd(input move_cmd_t c);
    if ((c.req_type == srpg_pkg::REQ_START) != plan_st.active) useful_items++;
    void'(ramp_step(plan_st, c));
    cmd_pending.push_back(c);
  endtask

  task automatic run_to_idle(input int noise_pct);
    while (plan_st.active) begin
      if ($urandom_range(0, 99) < noise_pct) queue_cmd(rand_cmd(srpg_pkg::REQ_START));
      queue_cmd(rand_cmd(srpg_pkg::REQ_TICK));
    end
  endtask

  task automatic plan_random_move();
    int m;
    int angle_top;
    m = int'(microsteps(plan_st.ms_pins));
    angle_top = ($urandom_range(0, 9) == 0) ? 90 / m : 36 / m;
    queue_cmd(make_cmd(srpg_pkg::REQ_START, 1'($urandom_range(0, 1)),
                       angle_t'($urandom_range(0, angle_top)),
                       speed_t'($urandom_range(0, 2 * m))));
    run_to_idle(6);
  endtask

  task automatic settle();
    while (cmd_pending.size() != 0 || cmd_bus.valid === 1'b1 ||
           levels_expected.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_microsteps(input logic [srpg_pkg::MS_W-1:0] pins);
    @(posedge clk);
    cfg_wdata <= pins;
    cfg_we <= 1'b1;
    @(posedge clk);
    cfg_we <= 1'b0;
    plan_st.ms_pins = pins;
    live_st.ms_pins = pins;
  endtask

  task automatic check_level(input string what, input bit want, input logic got);
    if (got !== want) begin
      $display("%0t: %s mismatch: expected %0b, actual %0b", $time, what, want, got);
      mismatches++;
    end
  endtask

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      cmd_bus.valid <= 1'b0;
      send_wait = 0;
    end else begin
      if (cmd_bus.valid && cmd_bus.ready) begin
        levels_expected.push_back(ramp_step(live_st, sent_cmd));
      end
      if (!cmd_bus.valid || cmd_bus.ready) begin
        if (send_wait > 0) begin
          send_wait--;
          cmd_bus.valid <= 1'b0;
        end else if (cmd_pending.size() > 0) begin
          sent_cmd = cmd_pending.pop_front();
          cmd_bus.valid <= 1'b1;
          cmd_bus.req_type <= sent_cmd.req_type;
          cmd_bus.direction <= sent_cmd.direction;
          cmd_bus.angle <= sent_cmd.angle;
          cmd_bus.speed <= sent_cmd.speed;
          send_wait = idle_draw(send_calm);
        end else begin
          cmd_bus.valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      res_bus.ready <= 1'b0;
      recv_wait = 0;
    end else begin
      if (res_bus.valid && res_bus.ready) begin
        if (levels_expected.size() == 0) begin
          $display("%0t: unexpected transaction: step %0b dir %0b enable %0b busy %0b ign %0b",
                   $time, res_bus.step_level, res_bus.dir_level, res_bus.enable_level,
                   res_bus.busy_res, res_bus.start_ignored);
          mismatches++;
        end else begin
          got_want = levels_expected.pop_front();
          check_level("step_level", got_want.step, res_bus.step_level);
          check_level("dir_level", got_want.dir, res_bus.dir_level);
          check_level("enable_level", got_want.enable, res_bus.enable_level);
          check_level("busy_res", got_want.busy, res_bus.busy_res);
          check_level("start_ignored", got_want.ignored, res_bus.start_ignored);
        end
        recv_wait = idle_draw(recv_calm);
      end
      if (recv_wait > 0) begin
        recv_wait--;
        res_bus.ready <= 1'b0;
      end else begin
        res_bus.ready <= 1'b1;
      end
    end
  end

  initial begin
    #10_000_000;
    $display("TB_ERROR");
    $finish;
  end

  initial begin
    int phase;
    int phase_start;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    cmd_bus.valid = 1'b0;
    cmd_bus.req_type = srpg_pkg::REQ_TICK;
    cmd_bus.direction = 1'b0;
    cmd_bus.angle = '0;
    cmd_bus.speed = '0;
    res_bus.ready = 1'b0;
    useful_items = 0;
    mismatches = 0;
    send_calm = 1'b0;
    recv_calm = 1'b0;
    plan_st = ramp_reset_state();
    live_st = ramp_reset_state();
    ms_order[0] = MS_PINS_16;
    ms_order[1] = MS_PINS_8;
    ms_order[2] = MS_PINS_4;
    ms_order[3] = MS_PINS_2;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: idle tick, zero-step move, zero speed, start during a move.
    queue_cmd(make_cmd(srpg_pkg::REQ_TICK, 1'b1, 16'hFFFF, 16'hFFFF));
    queue_cmd(make_cmd(srpg_pkg::REQ_START, 1'b1, 16'd0, 16'd100));
    queue_cmd(make_cmd(srpg_pkg::REQ_START, 1'b0, 16'd1, 16'd0));
    queue_cmd(make_cmd(srpg_pkg::REQ_START, 1'b1, 16'hFFFF, 16'hFFFF));
    run_to_idle(0);
    queue_cmd(make_cmd(srpg_pkg::REQ_START, 1'b1, 16'd1, 16'd4));
    run_to_idle(0);

    useful_items = 0;
    phase = 0;
    while (useful_items < RANDOM_ITEMS) begin
      settle();
      write_microsteps(ms_order[phase % 4]);
      phase++;
      phase_start = useful_items;
      while (useful_items - phase_start < PHASE_ITEMS) begin
        if ($urandom_range(0, 9) == 0) queue_cmd(rand_cmd(srpg_pkg::REQ_TICK));
        plan_random_move();
      end
    end

    // A maximal move that is still running when the bench ends.
    settle();
    queue_cmd(make_cmd(srpg_pkg::REQ_START, 1'b1, 16'hFFFF, 16'hFFFF));
    repeat (6) queue_cmd(rand_cmd(srpg_pkg::REQ_TICK));
    settle();

    if (mismatches == 0 && levels_expected.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
